[hw/rtl/mt_keystream_index_decryptor_core_assert.svh]
// Assertion macros used by the keystream decryptor RTL (mtkd_twister_gen).
// Depends on the including module having i_clk and i_rst_n in scope.
`ifndef MT_KEYSTREAM_INDEX_DECRYPTOR_CORE_ASSERT_SVH
`define MT_KEYSTREAM_INDEX_DECRYPTOR_CORE_ASSERT_SVH

// checked only while out of reset
`define MTKD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define MTKD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hw/rtl/mtkd_pkg.sv]
// Types and constants for the MT19937 keystream index decryptor.
// No dependencies.
package mtkd_pkg;

    localparam int ADDR_W = 10;

    localparam logic [ADDR_W-1:0] N_WORDS    = 10'd624;
    localparam logic [ADDR_W-1:0] M_OFFSET   = 10'd397;
    localparam logic [31:0]       MT_MATRIX  = 32'h9908_b0df;
    localparam logic [31:0]       SEED_MULT  = 32'd1812433253;
    localparam logic [31:0]       SEED_OFS   = 32'd6;
    localparam logic [31:0]       TEMPER_B   = 32'h9d2c_5680;
    localparam logic [31:0]       TEMPER_C   = 32'hefc6_0000;
    localparam logic [7:0]        KEY_A_INIT = 8'hc5;
    localparam logic [7:0]        KEY_B_INIT = 8'h83;
    localparam logic [7:0]        KEY_B_STEP = 8'h53;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic        valid;
        logic        restart;
        logic [31:0] seed;
    } t_gen_req;

    typedef struct packed {
        logic       ready;
        logic       word_valid;
        logic [7:0] word;
    } t_gen_rsp;

endpackage

[hw/rtl/mtkd_twister_ram.sv]
// 624 x 32 state memory: one write port, two read ports, registered reads.
// Depends on mtkd_pkg.
module mtkd_twister_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [mtkd_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [31:0]                i_wr_data,
    input  logic                       i_rd_en,
    input  logic [mtkd_pkg::ADDR_W-1:0] i_rd_addr_a,
    input  logic [mtkd_pkg::ADDR_W-1:0] i_rd_addr_b,
    output logic [31:0]                o_rd_data_a,
    output logic [31:0]                o_rd_data_b
);
    import mtkd_pkg::*;

    logic [31:0] r_mem [0:N_WORDS-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

[hw/rtl/mtkd_twister_gen.sv]
// MT19937 engine: seeding sweep and per-word in-place twist with tempering.
// Depends on mtkd_pkg, mtkd_twister_ram and the assertion macro header.
module mtkd_twister_gen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtkd_pkg::t_gen_req i_req,
    input  logic               i_take,
    output mtkd_pkg::t_gen_rsp o_rsp
);
    import mtkd_pkg::*;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [31:0]       r_prev, n_prev;
    logic [31:0]       r_cur, n_cur;

    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [31:0]       rd_data_a;
    logic [31:0]       rd_data_b;

    logic [ADDR_W-1:0] pos_inc;
    logic [ADDR_W:0]   pos_m_sum;
    logic [ADDR_W-1:0] idx_inc;
    logic [31:0]       seed_mix;
    logic [31:0]       seed_next;
    logic [31:0]       twist_y;
    logic [31:0]       twist_v;
    logic [31:0]       t1, t2, t3, t4;
    logic              seed_last;
    logic              calc_take;

    mtkd_twister_ram u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // address arithmetic
    always_comb begin
        pos_inc   = (r_pos == N_WORDS - 10'd1) ? '0 : r_pos + 10'd1;
        pos_m_sum = {1'b0, r_pos} + {1'b0, M_OFFSET};
        if (pos_m_sum >= {1'b0, N_WORDS}) begin
            rd_addr_b = ADDR_W'(pos_m_sum - {1'b0, N_WORDS});
        end else begin
            rd_addr_b = pos_m_sum[ADDR_W-1:0];
        end
        rd_addr_a = pos_inc;
        idx_inc   = r_idx + 10'd1;
    end

    // seeding recurrence
    always_comb begin
        seed_mix  = r_prev ^ (r_prev >> 30);
        seed_next = (seed_mix * SEED_MULT) + {{(32-ADDR_W){1'b0}}, idx_inc};
    end

    // twist of word r_pos and tempering
    always_comb begin
        twist_y = {r_cur[31], rd_data_a[30:0]};
        twist_v = rd_data_b ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : 32'd0);
        t1 = twist_v ^ (twist_v >> 11);
        t2 = t1 ^ ((t1 << 7) & TEMPER_B);
        t3 = t2 ^ ((t2 << 15) & TEMPER_C);
        t4 = t3 ^ (t3 >> 18);
    end

    assign seed_last = (r_state == ST_SEED) && (r_idx == N_WORDS - 10'd1);
    assign calc_take = (r_state == ST_CALC) && i_take;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = i_req.restart ? ST_SEED : ST_CALC;
                end
            end
            ST_SEED: begin
                if (r_idx == N_WORDS - 10'd1) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CALC;
            ST_CALC: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.ready      = (r_state == ST_IDLE);
        o_rsp.word_valid = (r_state == ST_CALC);
        o_rsp.word       = t4[7:0];
        rd_en   = ((r_state == ST_IDLE) && i_req.valid && !i_req.restart)
                  || (r_state == ST_READ);
        wr_en   = (r_state == ST_SEED) || ((r_state == ST_CALC) && i_take);
        wr_addr = (r_state == ST_SEED) ? r_idx : r_pos;
        wr_data = (r_state == ST_SEED) ? r_prev : twist_v;
    end

    always_comb begin
        n_pos  = r_pos;
        n_idx  = r_idx;
        n_prev = r_prev;
        n_cur  = r_cur;
        if ((r_state == ST_IDLE) && i_req.valid && i_req.restart) begin
            n_pos  = '0;
            n_idx  = '0;
            n_prev = i_req.seed;
            n_cur  = i_req.seed;
        end else if (r_state == ST_SEED) begin
            n_idx  = idx_inc;
            n_prev = seed_next;
        end else if ((r_state == ST_CALC) && i_take) begin
            n_pos = pos_inc;
            n_cur = rd_data_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_prev <= n_prev;
        r_cur  <= n_cur;
    end

`include "mt_keystream_index_decryptor_core_assert.svh"

    `MTKD_ASSERT(a_seed_done, seed_last |=> (r_state == ST_READ), "seed sweep overran")
    `MTKD_ASSERT(a_read_then_calc, rd_en |=> (r_state == ST_CALC), "read not followed by calc")
    `MTKD_ASSERT(a_no_rw_overlap, !(rd_en && wr_en), "memory read and write in the same cycle")
    `MTKD_ASSERT(a_pos_step, calc_take |=> (r_pos == $past(pos_inc)), "position skipped")

endmodule

[hw/rtl/mt_keystream_index_decryptor_core.sv]
// Top level of the MT19937 keystream index decryptor.
// Depends on mtkd_pkg and mtkd_twister_gen.
//
// Usage:
//   Slave stream carries cipher bytes: tdata = cipher_byte, tuser = restart,
//   tlast = last mark. Master stream returns one plain byte per input beat,
//   tlast copied. The configuration port writes the index byte count; the
//   seed is that count + 6. Write it only while the block is idle.
//   A beat with restart set reseeds the generator and resets both keys
//   before that beat is decrypted.
// Processing steps:
//   Plain beat: accept with memory read of two state words, then compute
//   and write-back; the result is registered as the compute step completes.
//   Restart beat: accept, a seeding sweep of all 624 words (one state
//   word per cycle through the single write port), one read, one compute.
//   No new beat is accepted until the compute step has handed on its result.
// Reset clears the keys to their initial values, the index byte count to 0
// and empties the output register. Bytes before the first restart are undefined.
// A stalled master holds the output register; one more beat may be accepted
// and then waits in the compute stage until the output register frees.
module mt_keystream_index_decryptor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] cipher_byte
    input  logic        i_s_axis_tuser,   // [0] restart
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] plain_byte
    output logic        o_m_axis_tlast
);
    import mtkd_pkg::*;

    logic [31:0] r_idx_len;
    logic [7:0]  r_key_a, n_key_a;
    logic [7:0]  r_key_b, n_key_b;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_last;

    t_gen_req gen_req;
    t_gen_rsp gen_rsp;
    logic     out_free;
    logic     take;
    logic     accept;

    mtkd_twister_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (gen_req),
        .i_take  (take),
        .o_rsp   (gen_rsp)
    );

    always_comb begin
        gen_req.valid   = i_s_axis_tvalid;
        gen_req.restart = i_s_axis_tuser;
        gen_req.seed    = r_idx_len + SEED_OFS;
        accept          = i_s_axis_tvalid && gen_rsp.ready;
        out_free        = !r_out_valid || i_m_axis_tready;
        take            = gen_rsp.word_valid && out_free;
    end

    always_comb begin
        n_key_a     = r_key_a;
        n_key_b     = r_key_b;
        n_out_valid = r_out_valid;
        if (accept && i_s_axis_tuser) begin
            n_key_a = KEY_A_INIT;
            n_key_b = KEY_B_INIT;
        end else if (take) begin
            n_key_a = r_key_a + r_key_b;
            n_key_b = r_key_b + KEY_B_STEP;
        end
        if (take) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx_len   <= '0;
            r_key_a     <= KEY_A_INIT;
            r_key_b     <= KEY_B_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_idx_len <= i_cfg_wr_data;
            end
            r_key_a     <= n_key_a;
            r_key_b     <= n_key_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
        if (take) begin
            r_out_data <= r_byte ^ gen_rsp.word ^ r_key_a;
            r_out_last <= r_last;
        end
    end

    assign o_s_axis_tready = gen_rsp.ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

[tb/sv/mt_keystream_index_decryptor_core_tb.sv]
// Self-checking testbench for mt_keystream_index_decryptor_core: cipher beats in,
// plain beats checked against a built-in MT19937 keystream predictor.
// Depends on the RTL top level and the mtkd_pkg package it pulls in.
module mt_keystream_index_decryptor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TW_N     = 624;
    localparam int unsigned TW_M     = 397;
    localparam logic [31:0] TW_MAT   = 32'h9908_b0df;
    localparam logic [31:0] TW_UPPER = 32'h8000_0000;
    localparam logic [31:0] TW_LOWER = 32'h7fff_ffff;
    localparam logic [31:0] TW_MULT  = 32'd1812433253;
    localparam logic [31:0] TW_TMP_B = 32'h9d2c_5680;
    localparam logic [31:0] TW_TMP_C = 32'hefc6_0000;
    localparam logic [31:0] SEED_ADD = 32'd6;
    localparam logic [7:0]  KA_INIT  = 8'hc5;
    localparam logic [7:0]  KB_INIT  = 8'h83;
    localparam logic [7:0]  KB_STEP  = 8'h53;
    localparam int          MAX_SHOWN = 10;

    typedef struct packed {
        logic [7:0] plain;
        logic       last;
    } plain_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // [7:0] cipher_byte
    logic        i_s_axis_tuser = 1'b0; // [0] restart
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // [7:0] plain_byte
    logic        o_m_axis_tlast;

    // keystream predictor state
    logic [31:0] tw_words [TW_N];
    int unsigned tw_pos = TW_N;
    logic [7:0]  key_a = KA_INIT;
    logic [7:0]  key_b = KB_INIT;
    logic [31:0] index_len = '0;

    plain_beat_t expected_plain_q [$];

    bit src_gaps = 1'b0;
    bit snk_stalls = 1'b0;
    int err_count = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int restarts_sent = 0;
    int cfg_writes = 0;

    mt_keystream_index_decryptor_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < TW_N; i++) begin
            tw_words[i] = '0;
        end
    end

    function automatic void seed_words(input logic [31:0] s);
        int unsigned i;
        logic [31:0] p;
        tw_words[0] = s;
        for (i = 1; i < TW_N; i++) begin
            p = tw_words[i-1];
            tw_words[i] = TW_MULT * (p ^ (p >> 30)) + i;
        end
        tw_pos = TW_N;
    endfunction

    function automatic void twist_words();
        int unsigned i;
        logic [31:0] y;
        logic [31:0] v;
        for (i = 0; i < TW_N; i++) begin
            y = (tw_words[i] & TW_UPPER) | (tw_words[(i + 1) % TW_N] & TW_LOWER);
            v = tw_words[(i + TW_M) % TW_N] ^ (y >> 1);
            if (y[0]) begin
                v = v ^ TW_MAT;
            end
            tw_words[i] = v;
        end
        tw_pos = 0;
    endfunction

    function automatic logic [7:0] next_key_byte();
        logic [31:0] y;
        if (tw_pos >= TW_N) begin
            twist_words();
        end
        y = tw_words[tw_pos];
        tw_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TW_TMP_B);
        y = y ^ ((y << 15) & TW_TMP_C);
        y = y ^ (y >> 18);
        return y[7:0];
    endfunction

    function automatic void expect_plain(input logic [7:0] c, input logic rs, input logic lst);
        plain_beat_t b;
        if (rs) begin
            seed_words(index_len + SEED_ADD);
            key_a = KA_INIT;
            key_b = KB_INIT;
        end
        b.plain = c ^ next_key_byte() ^ key_a;
        b.last = lst;
        key_a = key_a + key_b;
        key_b = key_b + KB_STEP;
        expected_plain_q.push_back(b);
    endfunction

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_SHOWN) begin
            $display("%t: %s", $realtime, msg);
        end
    endfunction

    // sink side: random stalls per beat
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = snk_stalls ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        plain_beat_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_plain_q.size() == 0) begin
                flag_error($sformatf("unexpected beat: plain %h last %b",
                                     o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = expected_plain_q.pop_front();
                if (o_m_axis_tdata !== want.plain) begin
                    flag_error($sformatf("beat %0d plain_byte: expected %h, got %h",
                                         beats_checked, want.plain, o_m_axis_tdata));
                end
                if (o_m_axis_tlast !== want.last) begin
                    flag_error($sformatf("beat %0d last: expected %b, got %b",
                                         beats_checked, want.last, o_m_axis_tlast));
                end
            end
            beats_checked++;
        end
    end

    task automatic send_cipher(input logic [7:0] c, input logic rs, input logic lst);
        int gap;
        gap = src_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tuser  <= rs;
        i_s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expect_plain(c, rs, lst);
        beats_sent++;
        if (rs) begin
            restarts_sent++;
        end
    endtask

    // drop valid and wait until every plain beat is back
    task automatic settle_stream();
        i_s_axis_tvalid <= 1'b0;
        while (expected_plain_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_idx_len(input logic [31:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        index_len = v;
        cfg_writes++;
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_reset_seed();
        src_gaps = 1'b0;
        snk_stalls = 1'b0;
        send_cipher(8'h00, 1'b1, 1'b0);
        send_cipher(8'hff, 1'b0, 1'b0);
        send_cipher(8'ha5, 1'b0, 1'b0);
        send_cipher(8'h5a, 1'b0, 1'b1);
        src_gaps = 1'b1;
        snk_stalls = 1'b1;
        send_cipher(8'h3c, 1'b1, 1'b1);
        send_cipher(8'hc3, 1'b1, 1'b1);
        send_cipher(8'h81, 1'b0, 1'b0);
        settle_stream();
    endtask

    task automatic test_seed_extremes();
        logic [31:0] lens [4];
        lens = '{32'hffff_ffff, 32'hffff_fffa, 32'hffff_fff9, 32'h0000_0000};
        foreach (lens[k]) begin
            write_idx_len(lens[k]);
            send_cipher(8'($urandom), 1'b1, 1'b0);
            send_cipher(8'h00, 1'b0, 1'b0);
            send_cipher(8'hff, 1'b0, 1'b1);
            settle_stream();
        end
    endtask

    // one restart, then enough bytes to pass the table regeneration point
    task automatic test_long_run();
        int n;
        write_idx_len($urandom);
        for (n = 0; n < 626; n++) begin
            if (n % 90 == 0) begin
                src_gaps = $urandom_range(0, 1);
                snk_stalls = $urandom_range(0, 1);
            end
            send_cipher(8'($urandom), n == 0, n == 625);
        end
        settle_stream();
    endtask

    task automatic test_random_sessions();
        int total;
        int len;
        int n;
        logic rs;
        logic lst;
        total = 0;
        while (total < 20) begin
            src_gaps = $urandom_range(0, 3) != 0;
            snk_stalls = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 1)) begin
                write_idx_len($urandom);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
            for (n = 0; n < len; n++) begin
                if (n == 0) begin
                    rs = $urandom_range(0, 6) != 0;
                end else begin
                    rs = $urandom_range(0, 24) == 0;
                end
                lst = (n == len - 1) || ($urandom_range(0, 9) == 0);
                send_cipher(8'($urandom), rs, lst);
            end
            total += len;
            settle_stream();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_seed();
        test_seed_extremes();
        test_long_run();
        test_random_sessions();
        repeat (32) @(posedge i_clk);
        $display("sent %0d cipher beats with %0d restarts and %0d index length writes",
                 beats_sent, restarts_sent, cfg_writes);
        $display("checked %0d plain beats, %0d errors", beats_checked, err_count);
        if (err_count == 0 && expected_plain_q.size() == 0) begin
            $display("** mt_keystream_index_decryptor_core: PASSED **");
        end else begin
            $display("** mt_keystream_index_decryptor_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d plain beats outstanding", expected_plain_q.size());
        $display("** mt_keystream_index_decryptor_core: FAILED **");
        $finish;
    end

endmodule
